### rtl/grid_lattice_path_counter_core_macros.svh
// assertion helpers for the grid path counter
`ifndef GRID_LATTICE_PATH_COUNTER_CORE_MACROS_SVH
`define GRID_LATTICE_PATH_COUNTER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GLPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/glpc_pkg.sv
`default_nettype none
package glpc_pkg;

  // grid and count sizes
  localparam int MAX_DIM     = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int DIM_W       = 7;
  localparam int PATH_W      = 32;
  localparam int IDX_W       = $clog2(MAX_DIM);

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // per-cycle command from controller to datapath
  typedef struct packed {
    logic start;
    logic valid;
    logic first_row;
    logic first_col;
    logic last;
    idx_t addr;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/glpc_ctrl.sv
`default_nettype none
module glpc_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [glpc_pkg::DIM_W-1:0]     in_row_count,
  input  wire logic [glpc_pkg::DIM_W-1:0]     in_col_count,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output glpc_pkg::dp_cmd_t                   cmd,
  input  wire glpc_pkg::dp_sts_t              sts
);

  glpc_pkg::state_t st_r, st_nxt;
  glpc_pkg::idx_t   row_r, row_nxt;
  glpc_pkg::idx_t   col_r, col_nxt;
  glpc_pkg::idx_t   rows_m1_r, rows_m1_nxt;
  glpc_pkg::idx_t   cols_m1_r, cols_m1_nxt;
  logic             in_acc;
  logic             last_cell;
  logic             row_end;

  // size to last index, zero taken as one, oversize saturated
  function automatic glpc_pkg::idx_t clamp_m1(input logic [glpc_pkg::DIM_W-1:0] v);
    glpc_pkg::idx_t r;
    if (v == '0) begin
      r = '0;
    end else if (v > glpc_pkg::DIM_W'(glpc_pkg::MAX_DIM)) begin
      r = glpc_pkg::IDX_W'(glpc_pkg::MAX_DIM - 1);
    end else begin
      r = glpc_pkg::IDX_W'(v - 1'b1);
    end
    return r;
  endfunction

  assign row_end   = (col_r == cols_m1_r);
  assign last_cell = row_end && (row_r == rows_m1_r);
  assign in_acc    = in_valid && !in_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      glpc_pkg::ST_IDLE: begin
        if (in_acc) st_nxt = glpc_pkg::ST_RUN;
      end
      glpc_pkg::ST_RUN: begin
        if (last_cell) st_nxt = glpc_pkg::ST_DRAIN;
      end
      glpc_pkg::ST_DRAIN: begin
        if (sts.done) st_nxt = glpc_pkg::ST_OUT;
      end
      glpc_pkg::ST_OUT: begin
        if (in_acc) begin
          st_nxt = glpc_pkg::ST_RUN;
        end else if (!out_stall) begin
          st_nxt = glpc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = glpc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.addr      = col_r;
    cmd.first_row = (row_r == '0);
    cmd.first_col = (col_r == '0);
    cmd.last      = last_cell;
    case (st_r)
      glpc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      glpc_pkg::ST_RUN: begin
        cmd.valid = 1'b1;
      end
      glpc_pkg::ST_DRAIN: begin
        in_stall = 1'b1;
      end
      glpc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    cmd.start = in_valid && !in_stall;
  end

  // cell position walk
  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    rows_m1_nxt = rows_m1_r;
    cols_m1_nxt = cols_m1_r;
    if (in_acc) begin
      rows_m1_nxt = clamp_m1(in_row_count);
      cols_m1_nxt = clamp_m1(in_col_count);
      row_nxt     = '0;
      col_nxt     = '0;
    end else if (st_r == glpc_pkg::ST_RUN) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= glpc_pkg::ST_IDLE;
      row_r     <= '0;
      col_r     <= '0;
      rows_m1_r <= '0;
      cols_m1_r <= '0;
    end else begin
      st_r      <= st_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      rows_m1_r <= rows_m1_nxt;
      cols_m1_r <= cols_m1_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/glpc_dp.sv
`default_nettype none
module glpc_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  input  wire glpc_pkg::dp_cmd_t cmd,
  output glpc_pkg::dp_sts_t      sts,
  output glpc_pkg::cnt_t         res_count,
  output logic                   res_overflow
);

  // per-column line store
  glpc_pkg::cnt_t col_mem [glpc_pkg::MAX_DIM];

  logic           mode_r;
  glpc_pkg::cnt_t rdata_r;
  logic           byp_r;
  glpc_pkg::cnt_t byp_data_r;
  logic           v_b_r;
  logic           fr_b_r;
  logic           fc_b_r;
  logic           last_b_r;
  glpc_pkg::idx_t addr_b_r;
  glpc_pkg::cnt_t left_r, left_nxt;
  logic           ovf_r, ovf_nxt;
  glpc_pkg::cnt_t res_count_r;
  logic           res_ovf_r;

  glpc_pkg::cnt_t                   up;
  glpc_pkg::cnt_t                   up0;
  glpc_pkg::cnt_t                   left0;
  glpc_pkg::cnt_t                   cell_cnt;
  glpc_pkg::cnt_t                   col_wr;
  logic [glpc_pkg::COUNT_WIDTH:0]   sum_cell;
  logic [glpc_pkg::COUNT_WIDTH:0]   sum_col;
  logic [glpc_pkg::COUNT_WIDTH:0]   sum_row;
  logic                             carry;

  // value above, taken from the write in flight when it targets the same column
  assign up    = byp_r ? byp_data_r : rdata_r;
  assign up0   = (mode_r && fr_b_r) ? '0 : up;
  assign left0 = (mode_r && fc_b_r) ? '0 : left_r;

  // cell update
  always_comb begin
    sum_cell = {1'b0, up0} + {1'b0, left0};
    if (fr_b_r && (fc_b_r || !mode_r)) begin
      cell_cnt = glpc_pkg::COUNT_WIDTH'(1);
    end else if (fc_b_r && !mode_r) begin
      cell_cnt = glpc_pkg::COUNT_WIDTH'(1);
    end else begin
      cell_cnt = sum_cell[glpc_pkg::COUNT_WIDTH-1:0];
    end
    sum_col = {1'b0, up0} + {1'b0, cell_cnt};
    sum_row = {1'b0, left0} + {1'b0, cell_cnt};
    if (!mode_r) begin
      carry    = !(fr_b_r || fc_b_r) && sum_cell[glpc_pkg::COUNT_WIDTH];
      col_wr   = cell_cnt;
      left_nxt = cell_cnt;
    end else begin
      carry    = (!(fr_b_r && fc_b_r) && sum_cell[glpc_pkg::COUNT_WIDTH])
                 || sum_col[glpc_pkg::COUNT_WIDTH] || sum_row[glpc_pkg::COUNT_WIDTH];
      col_wr   = sum_col[glpc_pkg::COUNT_WIDTH-1:0];
      left_nxt = sum_row[glpc_pkg::COUNT_WIDTH-1:0];
    end
    ovf_nxt = ovf_r || carry;
  end

  // line store read and write
  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      rdata_r <= col_mem[cmd.addr];
    end
    if (v_b_r) begin
      col_mem[addr_b_r] <= col_wr;
    end
  end

  // bypass for a read of the column being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= cmd.valid && v_b_r && (addr_b_r == cmd.addr);
    end
    byp_data_r <= col_wr;
  end

  // second stage of the cell pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r  <= 1'b0;
      mode_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      v_b_r <= cmd.valid;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        ovf_r <= 1'b0;
      end else if (v_b_r) begin
        ovf_r <= ovf_nxt;
      end
    end
    fr_b_r   <= cmd.first_row;
    fc_b_r   <= cmd.first_col;
    last_b_r <= cmd.last;
    addr_b_r <= cmd.addr;
    if (v_b_r) begin
      left_r <= left_nxt;
    end
  end

  // result register, loaded by the last cell
  always_ff @(posedge clk) begin
    if (v_b_r && last_b_r) begin
      res_count_r <= cell_cnt;
      res_ovf_r   <= ovf_nxt;
    end
  end

  assign sts.done     = v_b_r && last_b_r;
  assign res_count    = res_count_r;
  assign res_overflow = res_ovf_r;

endmodule
`default_nettype wire

### rtl/grid_lattice_path_counter_core.sv
// Counts monotone paths from the top-left to the bottom-right cell of a grid.
// Input beat: in_row_count and in_col_count (0 taken as 1, above 64 saturated
// to 64), taken when in_valid is high and in_stall is low.
// Result beat: out_path_count (count modulo 2^32) and out_overflow (some sum
// of this beat carried out), taken when out_valid is high and out_stall low.
// cfg_wr_en/cfg_wr_data write step_mode: 0 = single-cell moves, 1 = moves of
// any length; write it only while no beat is in flight.
// One grid cell is computed per cycle by a two-stage loop over a 64-entry
// column store; the result shows once the last cell has loaded the result
// register and the controller has left its drain state.
// One beat is worked at a time: a new input is taken in the cycle its
// predecessor's result is taken.
// While the receiver stalls, the result holds and in_stall stays high.
// Synchronous reset clears the controller and sets step_mode to 0; the
// column store needs no clearing since each beat writes a column before
// reading it.
`default_nettype none
`include "grid_lattice_path_counter_core_macros.svh"
module grid_lattice_path_counter_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [glpc_pkg::DIM_W-1:0]    in_row_count,
  input  wire logic [glpc_pkg::DIM_W-1:0]    in_col_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [glpc_pkg::PATH_W-1:0]        out_path_count,
  output logic                               out_overflow
);

  glpc_pkg::dp_cmd_t cmd;
  glpc_pkg::dp_sts_t sts;
  glpc_pkg::cnt_t    res_count;
  logic              res_overflow;

  // sequencing
  glpc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_count (in_row_count),
    .in_col_count (in_col_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // cell arithmetic and column store
  glpc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .res_count    (res_count),
    .res_overflow (res_overflow)
  );

  assign out_path_count = glpc_pkg::PATH_W'(res_count);
  assign out_overflow   = res_overflow;

  // checks
  `GLPC_ASSERT_NEXT(a_acc_clears_out, in_valid && !in_stall, !out_valid, "result shown right after input beat")
  `GLPC_ASSERT_NEXT(a_done_shows_out, sts.done, out_valid, "finished item not presented")
  `GLPC_ASSERT_SAME(a_no_cmd_while_out, out_valid, !cmd.valid, "cell issued while result pending")

endmodule
`default_nettype wire
